[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

[sv/flha_pkg.sv]
// Types and constants of the free-list heap allocator.
package flha_pkg;
   localparam int ARENA_UNITS = 4096;
   localparam int IDX_W       = 13;
   localparam int ADDR_W      = 12;
   localparam int SIZE_W      = 12;
   localparam int BYTES_W     = 17;
   localparam int UNITS_W     = 14;  // a 17-bit request rounds up to 8192 units
   localparam int UNIT_SHIFT  = 4;   // 16-byte units
   localparam int PAGE_SHIFT  = 8;   // 256 units per page

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [BYTES_W-1:0] bytes_type;
   typedef logic [UNITS_W-1:0] units_type;
   typedef logic [1:0]         csr_idx_type;
   typedef logic [1:0]         csr_data_type;

   localparam idx_type DUMMY      = 13'd4096;
   localparam idx_type WALK_LIMIT = 13'd4098;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam csr_idx_type CSR_FIT      = 2'd0;
   localparam csr_idx_type CSR_START    = 2'd1;
   localparam csr_idx_type CSR_COALESCE = 2'd2;

   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FULL = 1'b1;
endpackage

[sv/free_list_heap_allocator_top.sv]
// Allocate walks the free list on the fit search, grows the heap by whole pages when nothing
// fits, walks again for the predecessor and splits a larger block; free links the block in
// after the rover without coalescing, and with it walks the address-ordered list and merges.
// One item in flight; the list walk through the registered link/size memories sets the rate.
// Synchronous reset empties the arena and points the dummy and rover at the dummy; no
// memory clearing pass is needed.
module free_list_heap_allocator_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  flha_pkg::csr_idx_type csr_index,
   input  flha_pkg::csr_data_type csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  flha_pkg::bytes_type   req_request_bytes,
   input  flha_pkg::addr_type    req_free_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output flha_pkg::addr_type    rsp_alloc_address
);
   import flha_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_AWALK  = 5'd1;
   localparam logic [4:0] S_AWALKD = 5'd2;
   localparam logic [4:0] S_AGROW  = 5'd3;
   localparam logic [4:0] S_AGROWD = 5'd4;
   localparam logic [4:0] S_AGROWL = 5'd5;
   localparam logic [4:0] S_APRED  = 5'd6;
   localparam logic [4:0] S_APREDD = 5'd7;
   localparam logic [4:0] S_ASPLIT = 5'd8;
   localparam logic [4:0] S_ASPOT  = 5'd9;
   localparam logic [4:0] S_ASPOTD = 5'd10;
   localparam logic [4:0] S_ASPSZ  = 5'd11;
   localparam logic [4:0] S_FRV    = 5'd12;
   localparam logic [4:0] S_FRVD   = 5'd13;
   localparam logic [4:0] S_FHT    = 5'd14;
   localparam logic [4:0] S_FH     = 5'd15;
   localparam logic [4:0] S_FHD    = 5'd16;
   localparam logic [4:0] S_FWALK  = 5'd17;
   localparam logic [4:0] S_FWALKD = 5'd18;
   localparam logic [4:0] S_FLH    = 5'd19;
   localparam logic [4:0] S_FLF    = 5'd20;
   localparam logic [4:0] S_FRH    = 5'd21;
   localparam logic [4:0] S_FRHD   = 5'd22;
   localparam logic [4:0] S_FRT    = 5'd23;
   localparam logic [4:0] S_FRTD   = 5'd24;
   localparam logic [4:0] S_FRF    = 5'd25;
   localparam logic [4:0] S_FRFD   = 5'd26;
   localparam logic [4:0] S_FRH2   = 5'd27;
   localparam logic [4:0] S_FRH2D  = 5'd28;
   localparam logic [4:0] S_RESP   = 5'd29;

   // Header memories
   idx_type  link_mem [ARENA_UNITS];
   size_type size_mem [ARENA_UNITS];
   idx_type  link_q;
   size_type size_q;

   logic [4:0] state_ff, state_in;
   idx_type  c_ff, c_in, start_ff, start_in, spot_ff, spot_in;
   units_type need_ff, need_in, units_ff, units_in;
   idx_type  steps_ff, steps_in;
   idx_type  rover_ff, rover_in, dummy_link_ff, dummy_link_in, top_ff, top_in;
   idx_type  h_ff, h_in, f_ff, f_in, rd_idx_ff;
   logic [13:0] end_ff, end_in;
   size_type best_ff, best_in;
   logic     first_ff, first_in;
   logic [1:0] fit_ff, fit_in;
   logic     start_sel_ff, start_sel_in, coal_ff, coal_in;
   logic     res_status_ff, res_status_in;
   addr_type res_addr_ff, res_addr_in;
   logic     rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   addr_type rsp_addr_ff, rsp_addr_in;

   idx_type  raddr;
   logic     lw_en, sw_en;
   idx_type  lw_idx, lw_val, sw_idx;
   size_type sw_val;

   // Node view with dummy and out-of-range handling
   idx_type  node_nx;
   size_type node_sz;
   always_comb begin
      if (rd_idx_ff == DUMMY) begin
         node_nx = dummy_link_ff;
      end else if (rd_idx_ff[IDX_W-1]) begin
         node_nx = DUMMY;
      end else begin
         node_nx = link_q;
      end
      node_sz = rd_idx_ff[IDX_W-1] ? '0 : size_q;
   end

   // Request sizing and growth
   bytes_type   bytes_eff;
   logic [17:0] bytes_sum;
   units_type   need_calc;
   logic [13:0] units_round, grow, room;
   always_comb begin
      bytes_eff   = (req_request_bytes == '0) ? bytes_type'(1) : req_request_bytes;
      bytes_sum   = {1'b0, bytes_eff} + 18'd15;
      need_calc   = UNITS_W'(bytes_sum >> UNIT_SHIFT);
      units_round = units_ff + 14'd255;
      grow        = (units_round >> PAGE_SHIFT) << PAGE_SHIFT;
      room        = 14'd4096 - {1'b0, top_ff};
   end

   // Fit step on the node just read
   size_type best_eff, best_new;
   logic     upd, cont, found;
   idx_type  steps_inc;
   always_comb begin
      best_eff  = first_ff ? node_sz : best_ff;
      steps_inc = steps_ff + 1'b1;
      case (fit_ff)
         FIT_BEST: begin
            upd = ({2'b0, node_sz} >= need_ff) &&
                  (({2'b0, best_eff} < need_ff) || (node_sz < best_eff));
         end
         FIT_WORST: begin
            upd = node_sz > best_eff;
         end
         default: begin
            upd = {2'b0, node_sz} >= need_ff;
         end
      endcase
      best_new = upd ? node_sz : best_eff;
      case (fit_ff)
         FIT_BEST: begin
            cont  = ({2'b0, best_new} != need_ff) && (node_nx != start_ff) &&
                    (steps_inc < WALK_LIMIT);
            found = {2'b0, best_new} >= need_ff;
         end
         FIT_WORST: begin
            cont  = (node_nx != start_ff) && (steps_inc < WALK_LIMIT);
            found = {2'b0, best_new} >= need_ff;
         end
         default: begin
            cont  = !upd && (node_nx != start_ff) && (steps_inc < WALK_LIMIT);
            found = upd;
         end
      endcase
   end

   logic split;
   assign split = {2'b0, best_ff} > need_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      c_in          = c_ff;
      start_in      = start_ff;
      spot_in       = spot_ff;
      need_in       = need_ff;
      units_in      = units_ff;
      steps_in      = steps_ff;
      rover_in      = rover_ff;
      dummy_link_in = dummy_link_ff;
      top_in        = top_ff;
      h_in          = h_ff;
      f_in          = f_ff;
      end_in        = end_ff;
      best_in       = best_ff;
      first_in      = first_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      raddr         = c_ff;
      lw_en         = 1'b0;
      lw_idx        = rover_ff;
      lw_val        = h_ff;
      sw_en         = 1'b0;
      sw_idx        = spot_ff;
      sw_val        = best_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_status_in = ST_OK;
               res_addr_in   = '0;
               h_in          = {1'b0, req_free_address - 1'b1};
               if (req_opcode == OP_ALLOC) begin
                  need_in  = need_calc;
                  units_in = need_calc + 1'b1;
                  start_in = start_sel_ff ? rover_ff : DUMMY;
                  rover_in = start_sel_ff ? rover_ff : DUMMY;
                  c_in     = start_sel_ff ? rover_ff : DUMMY;
                  spot_in  = start_sel_ff ? rover_ff : DUMMY;
                  steps_in = '0;
                  first_in = 1'b1;
                  state_in = S_AWALK;
               end else if (req_free_address == '0 ||
                            {1'b0, req_free_address} > top_ff) begin
                  state_in = S_RESP;
               end else if (coal_ff) begin
                  state_in = S_FH;
               end else begin
                  state_in = S_FRV;
               end
            end
         end
         S_AWALK: begin
            raddr    = c_ff;
            state_in = S_AWALKD;
         end
         S_AWALKD: begin
            first_in = 1'b0;
            best_in  = best_new;
            if (upd) begin
               spot_in = c_ff;
            end
            steps_in = steps_inc;
            c_in     = node_nx;
            if (cont) begin
               state_in = S_AWALK;
            end else begin
               rover_in = node_nx;
               if (found) begin
                  steps_in = '0;
                  state_in = S_APRED;
               end else begin
                  state_in = S_AGROW;
               end
            end
         end
         S_AGROW: begin
            raddr = rover_ff;
            if (grow > room) begin
               res_status_in = ST_FULL;
               state_in      = S_RESP;
            end else begin
               spot_in  = top_ff;
               best_in  = SIZE_W'(grow - 14'd1);
               state_in = S_AGROWD;
            end
         end
         S_AGROWD: begin
            lw_en    = 1'b1;
            lw_idx   = spot_ff;
            lw_val   = node_nx;
            sw_en    = 1'b1;
            sw_idx   = spot_ff;
            sw_val   = best_ff;
            state_in = S_AGROWL;
         end
         S_AGROWL: begin
            lw_en    = 1'b1;
            lw_idx   = rover_ff;
            lw_val   = spot_ff;
            top_in   = IDX_W'({1'b0, top_ff} + grow);
            c_in     = rover_ff;
            steps_in = '0;
            state_in = S_APRED;
         end
         S_APRED: begin
            raddr    = c_ff;
            state_in = S_APREDD;
         end
         S_APREDD: begin
            if (node_nx == spot_ff) begin
               rover_in = c_ff;
               state_in = split ? S_ASPLIT : S_ASPOT;
            end else if (steps_ff >= WALK_LIMIT) begin
               res_status_in = ST_FULL;
               state_in      = S_RESP;
            end else begin
               c_in     = node_nx;
               steps_in = steps_inc;
               state_in = S_APRED;
            end
         end
         S_ASPLIT: begin
            lw_en    = 1'b1;
            lw_idx   = rover_ff;
            lw_val   = IDX_W'({1'b0, spot_ff} + units_ff);
            rover_in = IDX_W'({1'b0, spot_ff} + units_ff);
            state_in = S_ASPOT;
         end
         S_ASPOT: begin
            raddr    = spot_ff;
            state_in = S_ASPOTD;
         end
         S_ASPOTD: begin
            // rover holds the remainder after a split, else the predecessor
            lw_en  = 1'b1;
            lw_idx = rover_ff;
            lw_val = node_nx;
            res_addr_in = ADDR_W'(spot_ff + 1'b1);
            if (split) begin
               sw_en    = 1'b1;
               sw_idx   = rover_ff;
               sw_val   = SIZE_W'({2'b0, best_ff} - units_ff);
               state_in = S_ASPSZ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_ASPSZ: begin
            sw_en    = 1'b1;
            sw_idx   = spot_ff;
            sw_val   = SIZE_W'(need_ff);
            state_in = S_RESP;
         end
         S_FRV: begin
            raddr    = rover_ff;
            state_in = S_FRVD;
         end
         S_FRVD: begin
            c_in     = node_nx;
            lw_en    = 1'b1;
            lw_idx   = rover_ff;
            lw_val   = h_ff;
            state_in = S_FHT;
         end
         S_FHT: begin
            lw_en    = 1'b1;
            lw_idx   = h_ff;
            lw_val   = c_ff;
            rover_in = c_ff;
            state_in = S_RESP;
         end
         S_FH: begin
            raddr    = h_ff;
            state_in = S_FHD;
         end
         S_FHD: begin
            end_in   = {1'b0, h_ff} + {2'b0, node_sz} + 14'd1;
            f_in     = DUMMY;
            steps_in = '0;
            state_in = S_FWALK;
         end
         S_FWALK: begin
            raddr    = f_ff;
            state_in = S_FWALKD;
         end
         S_FWALKD: begin
            if ({1'b0, node_nx} < end_ff && node_nx != DUMMY && steps_ff < WALK_LIMIT) begin
               f_in     = node_nx;
               steps_in = steps_inc;
               state_in = S_FWALK;
            end else begin
               c_in     = node_nx;
               state_in = S_FLH;
            end
         end
         S_FLH: begin
            lw_en    = 1'b1;
            lw_idx   = h_ff;
            lw_val   = c_ff;
            state_in = S_FLF;
         end
         S_FLF: begin
            lw_en    = 1'b1;
            lw_idx   = f_ff;
            lw_val   = h_ff;
            state_in = S_FRH;
         end
         S_FRH: begin
            raddr    = h_ff;
            state_in = S_FRHD;
         end
         S_FRHD: begin
            // merge with the following block when it touches
            if (({1'b0, h_ff} + {2'b0, node_sz} + 14'd1) == {1'b0, node_nx} &&
                node_nx != DUMMY) begin
               c_in     = node_nx;
               best_in  = node_sz;
               state_in = S_FRT;
            end else begin
               state_in = S_FRF;
            end
         end
         S_FRT: begin
            raddr    = c_ff;
            state_in = S_FRTD;
         end
         S_FRTD: begin
            sw_en    = 1'b1;
            sw_idx   = h_ff;
            sw_val   = best_ff + node_sz + 1'b1;
            lw_en    = 1'b1;
            lw_idx   = h_ff;
            lw_val   = node_nx;
            state_in = S_FRF;
         end
         S_FRF: begin
            raddr    = f_ff;
            rover_in = f_ff;
            state_in = (f_ff == DUMMY) ? S_RESP : S_FRFD;
         end
         S_FRFD: begin
            // merge into the preceding block when it touches
            if (({1'b0, f_ff} + {2'b0, node_sz} + 14'd1) == {1'b0, h_ff}) begin
               best_in  = node_sz;
               state_in = S_FRH2;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FRH2: begin
            raddr    = h_ff;
            state_in = S_FRH2D;
         end
         S_FRH2D: begin
            sw_en    = 1'b1;
            sw_idx   = f_ff;
            sw_val   = best_ff + node_sz + 1'b1;
            lw_en    = 1'b1;
            lw_idx   = f_ff;
            lw_val   = node_nx;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (lw_en && lw_idx == DUMMY) begin
         dummy_link_in = lw_val;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (state_ff == S_RESP && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_addr_in   = res_addr_ff;
      end
   end

   // Configuration
   always_comb begin
      fit_in       = fit_ff;
      start_sel_in = start_sel_ff;
      coal_in      = coal_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FIT:      fit_in       = csr_write_data;
            CSR_START:    start_sel_in = csr_write_data[0];
            CSR_COALESCE: coal_in      = csr_write_data[0];
            default:      fit_in       = fit_ff;
         endcase
      end
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (lw_en && !lw_idx[IDX_W-1]) begin
         link_mem[lw_idx[ADDR_W-1:0]] <= lw_val;
      end
      if (sw_en && !sw_idx[IDX_W-1]) begin
         size_mem[sw_idx[ADDR_W-1:0]] <= sw_val;
      end
      link_q <= link_mem[raddr[ADDR_W-1:0]];
      size_q <= size_mem[raddr[ADDR_W-1:0]];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rover_ff      <= DUMMY;
         dummy_link_ff <= DUMMY;
         top_ff        <= '0;
         fit_ff        <= FIT_FIRST;
         start_sel_ff  <= 1'b0;
         coal_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rover_ff      <= rover_in;
         dummy_link_ff <= dummy_link_in;
         top_ff        <= top_in;
         fit_ff        <= fit_in;
         start_sel_ff  <= start_sel_in;
         coal_ff       <= coal_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      c_ff          <= c_in;
      start_ff      <= start_in;
      spot_ff       <= spot_in;
      need_ff       <= need_in;
      units_ff      <= units_in;
      steps_ff      <= steps_in;
      h_ff          <= h_in;
      f_ff          <= f_in;
      end_ff        <= end_in;
      best_ff       <= best_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rd_idx_ff     <= raddr;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_alloc_address = rsp_addr_ff;
endmodule

[sv/flha_checker.sv]
// Port-level checks of the allocator and their bind.
module flha_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_status,
   input flha_pkg::addr_type     rsp_alloc_address
);
`include "assert_macros.svh"
   import flha_pkg::*;

   // one item in flight: an accepted beat closes the input
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "input open after accept")
   // failed allocation carries a null address
   `ASSERT_IMPLIES(a_fail_null, clock, reset, rsp_valid && rsp_status == ST_FULL, rsp_alloc_address == '0, "failure with address")
   // stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_alloc_address), "stalled beat changed")
endmodule

bind free_list_heap_allocator_top flha_checker u_flha_checker (.*);

[tb/tb.sv]
// Testbench for the free-list heap allocator: directed and random traffic checked against a built-in model.
`timescale 1ns / 1ps
module tb;
   import flha_pkg::*;

   typedef struct packed {
      logic      opcode;
      bytes_type nbytes;
      addr_type  faddr;
   } heap_op_type;

   typedef struct packed {
      logic     status;
      addr_type addr;
   } heap_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_write_enable = 1'b0;
   csr_idx_type  csr_index = CSR_FIT;
   csr_data_type csr_write_data = '0;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic         req_opcode = OP_ALLOC;
   bytes_type    req_request_bytes = '0;
   addr_type     req_free_address = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic         rsp_status;
   addr_type     rsp_alloc_address;

   free_list_heap_allocator_top i_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_request_bytes(req_request_bytes), .req_free_address(req_free_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_alloc_address(rsp_alloc_address)
   );

   always #5 clock = ~clock;

   // Heap model state
   int unsigned link_mem [ARENA_UNITS];
   int unsigned size_mem [ARENA_UNITS];
   int unsigned head_link, rover_idx, heap_top;
   int unsigned fit_mode, start_mode, merge_mode;
   localparam int unsigned HDR = ARENA_UNITS;
   localparam int unsigned WALK_MAX = ARENA_UNITS + 2;

   heap_op_type  pending_ops [$];
   heap_rsp_type expected_rsps [$];
   int unsigned live_blocks [$];
   int unsigned freed_blocks [$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_cycles = 0;
   int          hold_request = 0;
   int unsigned cycle_count = 0;

   function automatic int unsigned next_of(int unsigned i);
      if (i == HDR) return head_link;
      if (i < ARENA_UNITS) return link_mem[i];
      return HDR;
   endfunction

   function automatic int unsigned size_of(int unsigned i);
      return (i < ARENA_UNITS) ? size_mem[i] : 0;
   endfunction

   function automatic void set_next(int unsigned i, int unsigned v);
      if (i == HDR) head_link = v;
      else if (i < ARENA_UNITS) link_mem[i] = v;
   endfunction

   function automatic void set_size(int unsigned i, int unsigned v);
      if (i < ARENA_UNITS) size_mem[i] = v;
   endfunction

   function automatic heap_rsp_type model_alloc(int unsigned nbytes);
      heap_rsp_type r;
      int unsigned units, need, strt, c, spot, best, s, steps, pages, grow, rem;
      bit          found;
      r = '0;
      steps = 0;
      found = 0;
      if (nbytes == 0) nbytes = 1;
      units = (nbytes + 15) / 16 + 1;
      need = units - 1;
      if (start_mode == 0) rover_idx = HDR;
      strt = rover_idx;
      c = strt;
      spot = strt;
      best = size_of(strt);
      if (fit_mode == FIT_BEST) begin
         do begin
            s = size_of(c);
            if (s >= need && (best < need || s < best)) begin
               best = s;
               spot = c;
            end
            c = next_of(c);
            steps++;
         end while (best != need && c != strt && steps < WALK_MAX);
         found = best >= need;
      end else if (fit_mode == FIT_WORST) begin
         do begin
            s = size_of(c);
            if (s > best) begin
               best = s;
               spot = c;
            end
            c = next_of(c);
            steps++;
         end while (c != strt && steps < WALK_MAX);
         found = best >= need;
      end else begin
         do begin
            s = size_of(c);
            if (s >= need) begin
               best = s;
               spot = c;
               found = 1;
            end
            c = next_of(c);
            steps++;
         end while (!found && c != strt && steps < WALK_MAX);
      end
      rover_idx = c;
      // Grow by whole pages when nothing fits
      if (!found) begin
         pages = (units * 16 + 4095) / 4096;
         grow = pages * 256;
         if (grow > ARENA_UNITS - heap_top) begin
            r.status = ST_FULL;
            return r;
         end
         spot = heap_top;
         best = grow - 1;
         set_size(spot, best);
         set_next(spot, next_of(rover_idx));
         set_next(rover_idx, spot);
         heap_top += grow;
      end
      // Find the predecessor of the chosen block
      steps = 0;
      c = rover_idx;
      while (next_of(c) != spot) begin
         if (steps >= WALK_MAX) begin
            r.status = ST_FULL;
            return r;
         end
         c = next_of(c);
         steps++;
      end
      rover_idx = c;
      if (best > need) begin
         rem = spot + units;
         set_next(rover_idx, rem);
         rover_idx = rem;
         set_next(rem, next_of(spot));
         set_size(rem, best - units);
         set_size(spot, need);
      end else begin
         set_next(rover_idx, next_of(spot));
      end
      r.status = ST_OK;
      r.addr = addr_type'(spot + 1);
      return r;
   endfunction

   function automatic void model_free(int unsigned a);
      int unsigned h, t, f, end_idx, steps;
      steps = 0;
      if (a == 0 || a > heap_top) return;
      h = a - 1;
      if (merge_mode == 0) begin
         t = next_of(rover_idx);
         set_next(rover_idx, h);
         set_next(h, t);
         rover_idx = t;
         return;
      end
      end_idx = h + size_of(h) + 1;
      f = HDR;
      while (next_of(f) < end_idx && next_of(f) != HDR && steps < WALK_MAX) begin
         f = next_of(f);
         steps++;
      end
      set_next(h, next_of(f));
      set_next(f, h);
      if (h + size_of(h) + 1 == next_of(h) && next_of(h) != HDR) begin
         t = next_of(h);
         set_size(h, size_of(h) + size_of(t) + 1);
         set_next(h, next_of(t));
      end
      if (f != HDR && f + size_of(f) + 1 == h) begin
         set_size(f, size_of(f) + size_of(h) + 1);
         set_next(f, next_of(h));
      end
      rover_idx = f;
   endfunction

   // Queue one operation and its predicted response; track live blocks
   function automatic void push_op(logic op, int unsigned nbytes, int unsigned a);
      heap_op_type  o;
      heap_rsp_type r;
      o.opcode = op;
      o.nbytes = bytes_type'(nbytes);
      o.faddr = addr_type'(a);
      if (op == OP_ALLOC) begin
         r = model_alloc(nbytes);
         if (r.status == ST_OK) live_blocks.push_back(r.addr);
      end else begin
         model_free(a);
         r = '0;
      end
      pending_ops.push_back(o);
      expected_rsps.push_back(r);
   endfunction

   function automatic int unsigned pick_bytes();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 80) return $urandom_range(256, 1);
      if (p < 95) return $urandom_range(4096, 257);
      return $urandom_range(65536, 1);
   endfunction

   function automatic void push_random_op();
      int unsigned p, k, a;
      p = $urandom_range(99);
      if (p < 6) begin
         push_op(OP_FREE, $urandom, 0);
      end else if (p < 12) begin
         // free past the arena top is dropped
         a = (heap_top < 4095) ? $urandom_range(4095, heap_top + 1) : 0;
         push_op(OP_FREE, $urandom_range(65536, 0), a);
      end else if (live_blocks.size() > 0 &&
                   p < ((live_blocks.size() > 40) ? 65 : 45)) begin
         k = $urandom_range(live_blocks.size() - 1);
         a = live_blocks[k];
         live_blocks.delete(k);
         freed_blocks.push_back(a);
         push_op(OP_FREE, $urandom_range(65536, 0), a);
      end else begin
         push_op(OP_ALLOC, pick_bytes(), $urandom);
      end
   endfunction

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // Write all three registers on consecutive edges, block idle
   task automatic write_config(int unsigned fit, int unsigned strt, int unsigned merge);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_FIT;
      csr_write_data <= csr_data_type'(fit);
      @(posedge clock);
      csr_index <= CSR_START;
      csr_write_data <= csr_data_type'(strt);
      @(posedge clock);
      csr_index <= CSR_COALESCE;
      csr_write_data <= csr_data_type'(merge);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fit_mode = fit;
      start_mode = strt;
      merge_mode = merge;
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      errors++;
   endtask

   // Driver: hold a stalled beat, otherwise offer the next pending item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_opcode <= pending_ops[0].opcode;
            req_request_bytes <= pending_ops[0].nbytes;
            req_free_address <= pending_ops[0].faddr;
            void'(pending_ops.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_cycles <= hold_request;
         hold_request <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // Monitor: check each accepted beat against the oldest prediction
   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", rsp_alloc_address, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_alloc_address !== want.addr)
               report_mismatch("alloc_address", rsp_alloc_address, want.addr);
         end
      end
      rsp_stall <= (hold_cycles > 1) || ($urandom_range(99) < stall_pct);
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4000000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned phase_cfg [10][3] = '{
         '{1, 0, 0}, '{2, 1, 0}, '{0, 1, 1}, '{1, 1, 1}, '{2, 0, 1},
         '{3, 0, 0}, '{3, 1, 1}, '{0, 0, 1}, '{1, 0, 1}, '{2, 1, 1}};
      int idle_send [4] = '{0, 80, 0, 30};
      int idle_stall [4] = '{0, 0, 80, 30};
      int unsigned a;
      head_link = HDR;
      rover_idx = HDR;
      heap_top = 0;
      fit_mode = FIT_FIRST;
      start_mode = 0;
      merge_mode = 0;
      foreach (link_mem[i]) begin
         link_mem[i] = 0;
         size_mem[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_config(FIT_FIRST, 0, 0);

      // Directed: byte extremes, null and out-of-range frees, growth, exhaustion
      push_op(OP_ALLOC, 0, 0);
      push_op(OP_ALLOC, 1, 0);
      push_op(OP_ALLOC, 16, 0);
      push_op(OP_ALLOC, 17, 0);
      push_op(OP_ALLOC, 4080, 0);
      push_op(OP_ALLOC, 65536, 0);
      push_op(OP_ALLOC, 131071, 0);
      push_op(OP_FREE, 0, 0);
      push_op(OP_FREE, 65535, 4095);
      push_op(OP_FREE, 5, heap_top + 1);
      push_op(OP_ALLOC, 20000, 0);
      push_op(OP_ALLOC, 40000, 0);
      while (live_blocks.size() > 2) begin
         a = live_blocks.pop_front();
         freed_blocks.push_back(a);
         push_op(OP_FREE, 0, a);
      end
      push_op(OP_ALLOC, 8, 0);
      push_op(OP_ALLOC, 3000, 0);
      wait_drained();
      repeat (40) @(posedge clock);

      // Random phases over varied settings and all idle patterns
      for (int ph = 0; ph < 10; ph++) begin
         write_config(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
         send_idle_pct = idle_send[ph % 4];
         stall_pct = idle_stall[ph % 4];
         if (ph == 1) hold_request = 400;
         for (int n = 0; n < 112; n++) begin
            push_random_op();
            if (ph == 4 && n == 56) wait_drained();
         end
         wait_drained();
         repeat (40) @(posedge clock);
      end

      // Last: a few double frees that corrupt the list
      write_config(FIT_WORST, 1, 1);
      send_idle_pct = 0;
      stall_pct = 0;
      for (int n = 0; n < 12; n++) begin
         if (n % 4 == 0 && freed_blocks.size() != 0)
            push_op(OP_FREE, 0, freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
         else
            push_random_op();
      end
      wait_drained();
      repeat (100) @(posedge clock);

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
